// ===== rtl/fixed_string_record_filter_assert.svh =====
// ----------------------------------------------------------------------------
// fixed_string_record_filter assertion macros
// Concurrent assertion wrappers on clk with synchronous reset rst; they
// expand to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FIXED_STRING_RECORD_FILTER_ASSERT_SVH
`define FIXED_STRING_RECORD_FILTER_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define FSRF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fsrf assertion failed");
// next-cycle implication
`define FSRF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fsrf assertion failed");
`else
`define FSRF_ASSERT_IMP(label, ante, cons)
`define FSRF_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== rtl/fsrf_pkg.sv =====
// ----------------------------------------------------------------------------
// fsrf_pkg
// Shared constants, pattern kind codes and register indexes of the record
// filter.
// ----------------------------------------------------------------------------
package fsrf_pkg;

  // register file slots and field widths
  localparam int SLOTS     = 4;
  localparam int BYTE_W    = 8;
  localparam int PAT_W     = 64;
  localparam int LEN_W     = 4;
  localparam int KIND_W    = 2;
  localparam int COUNT_W   = 3;
  localparam int KINDS_W   = SLOTS * KIND_W;
  localparam int LENS_W    = SLOTS * LEN_W;
  localparam int DATA_W    = 64;
  localparam int ADDR_W    = 6;
  localparam int REG_IDX_W = 3;

  // default longest pattern in bytes
  localparam int PATTERN_BYTES_DEF = 8;

  // reset value of the kinds register: every slot disabled
  localparam logic [KINDS_W-1:0] KINDS_RESET = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_NOT  = 2'd0,
    KIND_MUST = 2'd1,
    KIND_IF   = 2'd2,
    KIND_OFF  = 2'd3
  } kind_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_COUNT   = 3'd0,
    REG_KINDS   = 3'd1,
    REG_LENGTHS = 3'd2,
    REG_PAT0    = 3'd3,
    REG_PAT1    = 3'd4,
    REG_PAT2    = 3'd5,
    REG_PAT3    = 3'd6
  } reg_idx_t;

endpackage

// ===== rtl/fixed_string_record_filter.sv =====
// ----------------------------------------------------------------------------
// fixed_string_record_filter
// Result: a record's last byte is registered in the input stage, then sets the result register.
// Throughput: one byte per cycle; a record end waits only on an untaken result.
// Reset: rst clears window, fill, found and held flags, handshake and registers.
// ----------------------------------------------------------------------------
module fixed_string_record_filter #(
  parameter int PATTERN_BYTES = fsrf_pkg::PATTERN_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // record byte channel
  input  logic                           text_valid,
  output logic                           text_ready,
  input  logic [fsrf_pkg::BYTE_W-1:0]    text_byte,
  input  logic                           end_of_record,
  // result channel
  output logic                           result_valid,
  input  logic                           result_ready,
  output logic                           reject,
  output logic [fsrf_pkg::SLOTS-1:0]     if_absent_flags,
  // register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fsrf_pkg::ADDR_W-1:0]    paddr,
  input  logic [fsrf_pkg::DATA_W-1:0]    pwdata,
  output logic [fsrf_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);
  import fsrf_pkg::*;

  `include "fixed_string_record_filter_assert.svh"

  localparam int WIN_D  = (PATTERN_BYTES > 1) ? PATTERN_BYTES - 1 : 1;
  localparam int FILL_W = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(PATTERN_BYTES - 1);

  // registers
  logic [COUNT_W-1:0]           pattern_count;
  logic [KINDS_W-1:0]           pattern_kinds;
  logic [LENS_W-1:0]            pattern_lengths;
  logic [SLOTS-1:0][PAT_W-1:0]  patterns;
  reg_idx_t                     reg_idx;
  logic                         reg_write;

  // input stage
  logic                         s1_valid;
  logic [BYTE_W-1:0]            s1_byte;
  logic                         s1_last;
  logic                         s1_advance;

  // record state
  logic [WIN_D-1:0][BYTE_W-1:0] window;
  logic [WIN_D-1:0][BYTE_W-1:0] window_next;
  logic [FILL_W-1:0]            window_fill;
  logic [FILL_W-1:0]            fill_next;
  logic [SLOTS-1:0]             found_flags;
  logic [SLOTS-1:0]             found_next;
  logic [SLOTS-1:0]             held_if_flags;
  logic [SLOTS-1:0]             held_next;
  logic                         reject_next;

  // per-slot match results
  logic [SLOTS-1:0]             slot_hit;
  logic [SLOTS-1:0]             slot_empty;
  logic [SLOTS-1:0]             slot_active;
  logic [COUNT_W-1:0]           active_n;

  // register port decode
  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_t'(paddr[ADDR_W-1:ADDR_W-REG_IDX_W]);
  assign reg_write = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_count   <= '0;
      pattern_kinds   <= KINDS_RESET;
      pattern_lengths <= '0;
      patterns        <= '0;
    end else if (reg_write) begin
      case (reg_idx)
        REG_COUNT:   pattern_count   <= pwdata[COUNT_W-1:0];
        REG_KINDS:   pattern_kinds   <= pwdata[KINDS_W-1:0];
        REG_LENGTHS: pattern_lengths <= pwdata[LENS_W-1:0];
        REG_PAT0:    patterns[0]     <= pwdata;
        REG_PAT1:    patterns[1]     <= pwdata;
        REG_PAT2:    patterns[2]     <= pwdata;
        REG_PAT3:    patterns[3]     <= pwdata;
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (reg_idx)
      REG_COUNT:   prdata = DATA_W'(pattern_count);
      REG_KINDS:   prdata = DATA_W'(pattern_kinds);
      REG_LENGTHS: prdata = DATA_W'(pattern_lengths);
      REG_PAT0:    prdata = patterns[0];
      REG_PAT1:    prdata = patterns[1];
      REG_PAT2:    prdata = patterns[2];
      REG_PAT3:    prdata = patterns[3];
      default:     prdata = '0;
    endcase
  end

  // input stage handshake: a record end needs a free result register
  assign s1_advance = s1_valid && (!s1_last || !result_valid || result_ready);
  assign text_ready = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text_ready) begin
      s1_valid <= text_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text_valid && text_ready) begin
      s1_byte <= text_byte;
      s1_last <= end_of_record;
    end
  end

  // slots in use, clamped to the register slots
  assign active_n = (pattern_count > COUNT_W'(SLOTS)) ? COUNT_W'(SLOTS) : pattern_count;

  // per-slot comparators
  for (genvar s = 0; s < SLOTS; s++) begin : g_slot
    fsrf_slot_match #(
      .PATTERN_BYTES (PATTERN_BYTES),
      .WIN_D         (WIN_D),
      .FILL_W        (FILL_W)
    ) u_match (
      .pattern  (patterns[s]),
      .raw_len  (pattern_lengths[s*LEN_W +: LEN_W]),
      .cur_byte (s1_byte),
      .window   (window),
      .fill     (window_fill),
      .hit      (slot_hit[s]),
      .empty    (slot_empty[s])
    );
    assign slot_active[s] = (COUNT_W'(s) < active_n);
  end

  // found flags, reject and held if-test flags
  always_comb begin
    kind_t kind;
    found_next  = found_flags | (slot_active & (slot_hit | slot_empty));
    reject_next = 1'b0;
    held_next   = held_if_flags;
    for (int s = 0; s < SLOTS; s++) begin
      kind = kind_t'(pattern_kinds[s*KIND_W +: KIND_W]);
      if (slot_active[s]) begin
        if (kind == KIND_NOT && found_next[s])  reject_next = 1'b1;
        if (kind == KIND_MUST && !found_next[s]) reject_next = 1'b1;
      end
    end
    for (int s = 0; s < SLOTS; s++) begin
      kind = kind_t'(pattern_kinds[s*KIND_W +: KIND_W]);
      if (!reject_next && slot_active[s] && kind == KIND_IF) begin
        held_next[s] = !found_next[s];
      end
    end
  end

  // window shift, newest byte at entry 0
  always_comb begin
    window_next[0] = s1_byte;
    for (int k = 1; k < WIN_D; k++) begin
      window_next[k] = window[k-1];
    end
    fill_next = (window_fill < FILL_MAX) ? window_fill + FILL_W'(1) : window_fill;
  end

  // record state update; window, fill and found flags cleared at record end
  always_ff @(posedge clk) begin
    if (rst) begin
      window        <= '0;
      window_fill   <= '0;
      found_flags   <= '0;
      held_if_flags <= '0;
    end else if (s1_advance) begin
      if (s1_last) begin
        window        <= '0;
        window_fill   <= '0;
        found_flags   <= '0;
        held_if_flags <= held_next;
      end else begin
        window        <= window_next;
        window_fill   <= fill_next;
        found_flags   <= found_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_advance && s1_last) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_last) begin
      reject          <= reject_next;
      if_absent_flags <= held_next;
    end
  end

  // window and fill restart after each record end
  `FSRF_ASSERT_NXT(a_fill_clear, s1_advance && s1_last, window_fill == '0 && found_flags == '0)
  // a new result only follows a record end
  `FSRF_ASSERT_IMP(a_result_src, $rose(result_valid), $past(s1_advance && s1_last))
  // held flags move only on a record that is not rejected
  `FSRF_ASSERT_IMP(a_held_upd, !$stable(held_if_flags), $past(s1_advance && s1_last && !reject_next))
  // a record end never overwrites a result still waiting
  `FSRF_ASSERT_IMP(a_no_overrun, s1_advance && s1_last && result_valid, result_ready)

endmodule

// ===== rtl/fsrf_slot_match.sv =====
// ----------------------------------------------------------------------------
// fsrf_slot_match
// Checks whether one slot's pattern ends exactly at the current byte, using
// the current byte and the window of earlier bytes of the record.
// ----------------------------------------------------------------------------
module fsrf_slot_match #(
  parameter int PATTERN_BYTES = fsrf_pkg::PATTERN_BYTES_DEF,
  parameter int WIN_D         = (PATTERN_BYTES > 1) ? PATTERN_BYTES - 1 : 1,
  parameter int FILL_W        = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1
) (
  input  logic [fsrf_pkg::PAT_W-1:0]             pattern,
  input  logic [fsrf_pkg::LEN_W-1:0]             raw_len,
  input  logic [fsrf_pkg::BYTE_W-1:0]            cur_byte,
  input  logic [WIN_D-1:0][fsrf_pkg::BYTE_W-1:0] window,
  input  logic [FILL_W-1:0]                      fill,
  output logic                                   hit,
  output logic                                   empty
);
  import fsrf_pkg::*;

  logic [LEN_W-1:0]                      len;
  logic [PATTERN_BYTES-1:0][BYTE_W-1:0]  text;
  logic [PATTERN_BYTES-1:0]              byte_ok;
  logic [LEN_W-1:0]                      pidx;
  logic                                  fits;

  // clamp length to the longest supported pattern
  assign len   = (raw_len > LEN_W'(PATTERN_BYTES)) ? LEN_W'(PATTERN_BYTES) : raw_len;
  assign empty = (len == '0);

  // candidate text, newest byte first
  always_comb begin
    text[0] = cur_byte;
    for (int j = 1; j < PATTERN_BYTES; j++) begin
      text[j] = window[j-1];
    end
  end

  // per-position compare, pattern read backward from its last byte
  always_comb begin
    pidx = '0;
    for (int j = 0; j < PATTERN_BYTES; j++) begin
      pidx = len - LEN_W'(1) - LEN_W'(j);
      byte_ok[j] = (LEN_W'(j) >= len) ||
                   (pattern[pidx[2:0]*BYTE_W +: BYTE_W] == text[j]);
    end
  end

  // enough bytes of this record seen for the pattern to end here
  assign fits = ({1'b0, len} <= (5'(fill) + 5'd1));
  assign hit  = !empty && fits && (&byte_ok);

endmodule
